### sv/chunk_codebook_audio_decoder_assert.svh
// Assertion macros used by the decoder's top-level RTL file.
`ifndef CHUNK_CODEBOOK_AUDIO_DECODER_ASSERT_SVH
`define CHUNK_CODEBOOK_AUDIO_DECODER_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define CCAD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define CCAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ccad_pkg.sv
// Package with the decoder's constants, request types and sample formatting.
package ccad_pkg;

    localparam int CHUNK_SAMPLES    = 4;
    // Must be a power of two: chunk indexes wrap by masking.
    localparam int CHUNKS_PER_FRAME = 256;
    localparam int CODEBOOK_SIZE    = CHUNK_SAMPLES * CHUNKS_PER_FRAME;

    localparam int CB_AW = $clog2(CODEBOOK_SIZE);
    localparam int K_W   = $clog2(CHUNKS_PER_FRAME);
    localparam int J_W   = (CHUNK_SAMPLES > 1) ? $clog2(CHUNK_SAMPLES) : 1;

    localparam int BYTE_W         = 8;
    localparam int BLOCKS_W       = 16;
    localparam int CHUNKS_W       = 4;
    localparam int BLOCK_CHUNKS   = 8;
    localparam int HEADER_SHIFT   = 8;
    localparam int DAC_OFFSET     = 64;

    localparam int OUT_DEPTH = 4;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic             en;
        logic [CB_AW-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_cb_write;

    typedef struct packed {
        logic             valid;
        logic [CB_AW-1:0] addr;
        logic             raw;
        logic             last;
        logic             eot;
    } t_cb_read;

    typedef struct packed {
        logic [BYTE_W-1:0] dac_high;
        logic              dac_low_bit;
        logic              last_of_chunk;
        logic              end_of_track;
    } t_sample;

    function automatic t_sample format_sample(input logic [BYTE_W-1:0] s,
                                              input logic raw,
                                              input logic last,
                                              input logic eot);
        t_sample r;
        r.last_of_chunk = last;
        r.end_of_track  = eot;
        if (eot) begin
            r.dac_high    = '0;
            r.dac_low_bit = 1'b0;
            r.last_of_chunk = 1'b0;
        end else if (raw) begin
            r.dac_high    = s;
            r.dac_low_bit = 1'b1;
        end else begin
            r.dac_high    = {1'b0, s[BYTE_W-1:1]} + BYTE_W'(DAC_OFFSET);
            r.dac_low_bit = s[0];
        end
        return r;
    endfunction

endpackage

### sv/ccad_parser.sv
// Stream parser and sample read sequencer of the decoder.
module ccad_parser import ccad_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_stream_byte,
    input  logic              i_slot_ok,
    output t_cb_write         o_wr,
    output t_cb_read          o_rd
);

    typedef enum logic [1:0] {
        MODE_HEADER,
        MODE_LOAD,
        MODE_FLAG,
        MODE_INDEX
    } t_mode;

    t_mode               r_mode, n_mode;
    logic [CB_AW-1:0]    r_load_count, n_load_count;
    logic [BLOCKS_W-1:0] r_blocks_left, n_blocks_left;
    logic [BYTE_W-1:0]   r_flag_bits, n_flag_bits;
    logic [CHUNKS_W-1:0] r_chunks_left, n_chunks_left;
    logic                r_busy, n_busy;
    logic [J_W-1:0]      r_j, n_j;
    logic [K_W-1:0]      r_k, n_k;
    logic                r_raw, n_raw;

    logic            acc;
    logic [K_W-1:0]  k_in;
    logic            last_j;

    assign o_ready = i_slot_ok && !r_busy;
    assign acc     = i_valid && o_ready;
    assign k_in    = i_stream_byte[K_W-1:0];
    assign last_j  = (r_j == J_W'(CHUNK_SAMPLES - 1));

    always_comb begin
        n_mode        = r_mode;
        n_load_count  = r_load_count;
        n_blocks_left = r_blocks_left;
        n_flag_bits   = r_flag_bits;
        n_chunks_left = r_chunks_left;
        n_busy        = r_busy;
        n_j           = r_j;
        n_k           = r_k;
        n_raw         = r_raw;
        o_wr          = '0;
        o_rd          = '0;

        if (r_busy && i_slot_ok) begin
            // Remaining samples of the current chunk, one read per cycle while the queue has room.
            o_rd.valid = 1'b1;
            o_rd.addr  = (CB_AW'(r_j) << K_W) | CB_AW'(r_k);
            o_rd.raw   = r_raw;
            o_rd.last  = last_j;
            n_j        = r_j + J_W'(1);
            if (last_j) begin
                n_busy = 1'b0;
            end
        end

        if (acc) begin
            case (r_mode)
                MODE_LOAD: begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_load_count;
                    o_wr.data = i_stream_byte;
                    if (r_load_count == CB_AW'(CODEBOOK_SIZE - 1)) begin
                        n_load_count = '0;
                        n_mode       = MODE_FLAG;
                    end else begin
                        n_load_count = r_load_count + CB_AW'(1);
                    end
                end
                MODE_FLAG: begin
                    n_flag_bits   = i_stream_byte;
                    n_chunks_left = CHUNKS_W'(BLOCK_CHUNKS);
                    n_blocks_left = r_blocks_left - BLOCKS_W'(1);
                    n_mode        = MODE_INDEX;
                end
                MODE_INDEX: begin
                    o_rd.valid    = 1'b1;
                    o_rd.addr     = CB_AW'(k_in);
                    o_rd.raw      = r_flag_bits[BYTE_W-1];
                    o_rd.last     = (CHUNK_SAMPLES == 1);
                    n_busy        = (CHUNK_SAMPLES > 1);
                    n_j           = J_W'(1);
                    n_k           = k_in;
                    n_raw         = r_flag_bits[BYTE_W-1];
                    n_flag_bits   = {r_flag_bits[BYTE_W-2:0], 1'b0};
                    n_chunks_left = r_chunks_left - CHUNKS_W'(1);
                    if (n_chunks_left == '0) begin
                        n_mode = (r_blocks_left != '0) ? MODE_FLAG : MODE_HEADER;
                    end
                end
                default: begin
                    if (i_stream_byte == '0) begin
                        o_rd.valid = 1'b1;
                        o_rd.eot   = 1'b1;
                        n_mode     = MODE_HEADER;
                    end else begin
                        n_blocks_left = BLOCKS_W'({i_stream_byte, HEADER_SHIFT'(0)});
                        n_load_count  = '0;
                        n_mode        = MODE_LOAD;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_HEADER;
            r_load_count  <= '0;
            r_blocks_left <= '0;
            r_flag_bits   <= '0;
            r_chunks_left <= '0;
            r_busy        <= 1'b0;
            r_j           <= '0;
        end else begin
            r_mode        <= n_mode;
            r_load_count  <= n_load_count;
            r_blocks_left <= n_blocks_left;
            r_flag_bits   <= n_flag_bits;
            r_chunks_left <= n_chunks_left;
            r_busy        <= n_busy;
            r_j           <= n_j;
        end
        r_k   <= n_k;
        r_raw <= n_raw;
    end

endmodule

### sv/ccad_codebook.sv
// Codebook memory with one write port and one registered read port.
module ccad_codebook import ccad_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cb_write         i_wr,
    input  t_cb_read          i_rd,
    output logic [BYTE_W-1:0] o_rd_data,
    output t_cb_read          o_rd_meta
);

    logic [BYTE_W-1:0] r_mem [CODEBOOK_SIZE];
    logic [BYTE_W-1:0] r_rd_data;
    t_cb_read          r_rd_meta;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_meta <= '0;
        end else begin
            r_rd_meta <= i_rd;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_meta = r_rd_meta;

endmodule

### sv/ccad_out_fifo.sv
// Small output queue that decouples sample production from the consumer.
module ccad_out_fifo import ccad_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_sample           i_data,
    output logic [OCNT_W-1:0] o_count,
    output logic              o_valid,
    input  logic              i_ready,
    output t_sample           o_data
);

    t_sample             r_buf [OUT_DEPTH];
    logic [OPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [OCNT_W-1:0]   r_count;
    logic                pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_buf[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OPTR_W'(1);
            end
            r_count <= r_count + OCNT_W'(i_push) - OCNT_W'(pop);
        end
    end

endmodule

### sv/chunk_codebook_audio_decoder.sv
// Top level of the chunk codebook audio decoder: parser, codebook memory and output queue.
// Throughput: a chunk index byte is taken only after the single codebook read port has
// read out every sample of the previous chunk, one sample read per cycle while the queue has
// room; header, codebook and flag bytes are taken one per cycle while the queue has room.
// Samples are registered at the codebook read port, then queued and offered to the consumer.
// Reset (synchronous, active low) returns the parser to expect a header and empties the queue.
`include "chunk_codebook_audio_decoder_assert.svh"

module chunk_codebook_audio_decoder import ccad_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_stream_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_dac_high,
    output logic              o_dac_low_bit,
    output logic              o_last_of_chunk,
    output logic              o_end_of_track
);

    // Read requests issued by the parser, and the same requests registered in the codebook,
    // aligned with the data the codebook returns.
    t_cb_write         cb_wr;
    t_cb_read          rd_req;
    t_cb_read          rd_meta;
    logic [BYTE_W-1:0] rd_data;

    t_sample           sample;
    t_sample           out_sample;
    logic [OCNT_W-1:0] fifo_count;
    logic [OCNT_W-1:0] credit;
    logic              credit_ok;
    logic              slot_ok;
    logic              eot_req;
    logic              zero_hdr;

    // A read may only be issued while the queue has room for it counting the
    // sample still in flight through the memory, so nothing is ever dropped
    // when the consumer stalls. Depth four keeps one read per cycle going if the consumer keeps up.
    assign credit    = fifo_count + OCNT_W'(rd_meta.valid);
    assign slot_ok   = credit < OCNT_W'(OUT_DEPTH);
    assign credit_ok = credit <= OCNT_W'(OUT_DEPTH);

    // An end of track marker may only be raised by an accepted zero header.
    assign eot_req  = rd_req.valid && rd_req.eot;
    assign zero_hdr = i_valid && o_ready && (i_stream_byte == '0);

    ccad_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_stream_byte (i_stream_byte),
        .i_slot_ok     (slot_ok),
        .o_wr          (cb_wr),
        .o_rd          (rd_req)
    );

    // Loading writes and sample reads never touch the same entry in
    // overlapping cycles: the parser takes no byte while a chunk is still
    // being read out, and a same-cycle write and read returns the old data.
    ccad_codebook u_codebook (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (cb_wr),
        .i_rd      (rd_req),
        .o_rd_data (rd_data),
        .o_rd_meta (rd_meta)
    );

    // The end of track marker rides the same path as samples so that it
    // keeps its place behind the samples of the last chunk.
    assign sample = format_sample(rd_data, rd_meta.raw, rd_meta.last, rd_meta.eot);

    ccad_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rd_meta.valid),
        .i_data  (sample),
        .o_count (fifo_count),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_sample)
    );

    assign o_dac_high      = out_sample.dac_high;
    assign o_dac_low_bit   = out_sample.dac_low_bit;
    assign o_last_of_chunk = out_sample.last_of_chunk;
    assign o_end_of_track  = out_sample.end_of_track;

    `CCAD_ASSERT_ALWAYS(a_queue_credit, i_clk, i_rst_n, credit_ok, "output queue credit exceeded")
    `CCAD_ASSERT_NEXT(a_read_returns, i_clk, i_rst_n, rd_req.valid, rd_meta.valid, "read dropped")
    `CCAD_ASSERT_ALWAYS(a_eot_on_zero, i_clk, i_rst_n, !eot_req || zero_hdr, "stray end of track")

endmodule

### test/ccad_tb_pkg.sv
// Expected-sample tracker for the chunk codebook audio decoder testbench.
`timescale 1ns / 100ps

package ccad_tb_pkg;

    import ccad_pkg::*;

    typedef enum logic [2:0] {
        PARSE_HEADER,
        PARSE_CODEBOOK,
        PARSE_FLAG,
        PARSE_INDEX
    } t_parse_mode;

    class dac_sample_tracker;

        logic [BYTE_W-1:0]   codebook_copy [CODEBOOK_SIZE];
        t_parse_mode         mode;
        int unsigned         fill_idx;
        logic [BLOCKS_W-1:0] blocks_to_go;
        logic [BYTE_W-1:0]   flags;
        logic [CHUNKS_W-1:0] chunks_to_go;
        t_sample             awaited [$];

        int unsigned mismatches;
        int unsigned samples_checked;
        int unsigned track_ends;
        int unsigned frames_started;

        function new();
            foreach (codebook_copy[a]) codebook_copy[a] = '0;
            mode            = PARSE_HEADER;
            fill_idx        = 0;
            blocks_to_go    = '0;
            flags           = '0;
            chunks_to_go    = '0;
            mismatches      = 0;
            samples_checked = 0;
            track_ends      = 0;
            frames_started  = 0;
        endfunction

        function void note_mismatch(string what);
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] %s", $time, what);
            end
        endfunction

        // Works out the samples that one accepted stream byte must produce.
        function void take_stream_byte(logic [BYTE_W-1:0] b);
            t_sample           s;
            logic [BYTE_W-1:0] word;
            int unsigned       chunk;
            case (mode)
                PARSE_CODEBOOK: begin
                    codebook_copy[fill_idx] = b;
                    fill_idx++;
                    if (fill_idx == CODEBOOK_SIZE) begin
                        fill_idx = 0;
                        mode     = PARSE_FLAG;
                    end
                end
                PARSE_FLAG: begin
                    flags        = b;
                    chunks_to_go = CHUNKS_W'(BLOCK_CHUNKS);
                    blocks_to_go = blocks_to_go - 1'b1;
                    mode         = PARSE_INDEX;
                end
                PARSE_INDEX: begin
                    chunk = b % CHUNKS_PER_FRAME;
                    for (int j = 0; j < CHUNK_SAMPLES; j++) begin
                        word = codebook_copy[(chunk + CHUNKS_PER_FRAME * j) % CODEBOOK_SIZE];
                        if (flags[BYTE_W-1]) begin
                            s.dac_high    = word;
                            s.dac_low_bit = 1'b1;
                        end else begin
                            s.dac_high    = (word >> 1) + BYTE_W'(DAC_OFFSET);
                            s.dac_low_bit = word[0];
                        end
                        s.last_of_chunk = (j == CHUNK_SAMPLES - 1);
                        s.end_of_track  = 1'b0;
                        awaited.push_back(s);
                    end
                    flags        = flags << 1;
                    chunks_to_go = chunks_to_go - 1'b1;
                    if (chunks_to_go == 0) begin
                        mode = (blocks_to_go != 0) ? PARSE_FLAG : PARSE_HEADER;
                    end
                end
                default: begin
                    mode = PARSE_HEADER;
                    if (b == 0) begin
                        s              = '0;
                        s.end_of_track = 1'b1;
                        awaited.push_back(s);
                    end else begin
                        blocks_to_go = BLOCKS_W'(b) << HEADER_SHIFT;
                        fill_idx     = 0;
                        mode         = PARSE_CODEBOOK;
                        frames_started++;
                    end
                end
            endcase
        endfunction

        function void check_sample(t_sample got);
            t_sample want;
            if (awaited.size() == 0) begin
                note_mismatch($sformatf("unexpected sample: high=%02h low=%0b last=%0b eot=%0b",
                              got.dac_high, got.dac_low_bit, got.last_of_chunk,
                              got.end_of_track));
                return;
            end
            want = awaited.pop_front();
            samples_checked++;
            if (want.end_of_track) begin
                track_ends++;
            end
            if (got.dac_high !== want.dac_high || got.dac_low_bit !== want.dac_low_bit ||
                got.last_of_chunk !== want.last_of_chunk ||
                got.end_of_track !== want.end_of_track) begin
                note_mismatch($sformatf(
                    "sample %0d: expected high=%02h low=%0b last=%0b eot=%0b, got high=%02h low=%0b last=%0b eot=%0b",
                    samples_checked, want.dac_high, want.dac_low_bit, want.last_of_chunk,
                    want.end_of_track, got.dac_high, got.dac_low_bit, got.last_of_chunk,
                    got.end_of_track));
            end
        endfunction

        function void flush_leftovers();
            if (awaited.size() != 0) begin
                note_mismatch($sformatf("%0d expected samples never arrived", awaited.size()));
                awaited.delete();
            end
        endfunction

    endclass

endpackage

### test/tb_top.sv
// Top-level testbench that streams frames into the decoder and checks every DAC sample.
`timescale 1ns / 100ps

module tb_top;

    import ccad_pkg::*;
    import ccad_tb_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 9;
    // Long receiver hold-off, so that the output queue fills and requests back up.
    localparam int HOLD_OFF_CYCLES = 300;
    // Cycles allowed after the last expected sample for anything stray to show up.
    localparam int DRAIN_CYCLES    = 32;
    // Number of blocks sent after the codebook.
    localparam int FRAME_BLOCKS    = 20;
    // Watchdog limit in clock cycles; it leaves ample margin over the slowest legal run.
    localparam int LIMIT_CYCLES    = 200_000;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic [BYTE_W-1:0] i_stream_byte = '0;
    logic              i_ready       = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [BYTE_W-1:0] o_dac_high;
    logic              o_dac_low_bit;
    logic              o_last_of_chunk;
    logic              o_end_of_track;

    dac_sample_tracker tracker = new();

    // Requests still to go in the sender's current burst.
    int unsigned burst_left = 0;
    int unsigned bytes_sent = 0;

    chunk_codebook_audio_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_stream_byte   (i_stream_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_dac_high      (o_dac_high),
        .o_dac_low_bit   (o_dac_low_bit),
        .o_last_of_chunk (o_last_of_chunk),
        .o_end_of_track  (o_end_of_track)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Offers one stream byte as a request and waits until the decoder takes it.
    // Called at a falling edge and returns at a falling edge. When a burst runs
    // out, valid drops for a random gap, unless the gap drawn is zero, in which
    // case valid simply stays high so that it is never lowered and raised in the
    // same time step.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            // Now and then a long burst gives a stretch with no idling at all.
            if ($urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(200, 600);
            end else begin
                burst_left = $urandom_range(1, 32);
            end
        end
        i_valid       <= 1'b1;
        i_stream_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tracker.take_stream_byte(b);
        bytes_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // Sends a header, a full codebook and then the given number of blocks.
    // In the directed form, chunks 0 and 255 carry the extreme sample values
    // and the first blocks use fixed flag patterns over those two chunks, so
    // that raw and offset formatting both see the smallest and largest bytes.
    task automatic play_frame(input logic [BYTE_W-1:0] header, input int unsigned blocks,
                              input bit directed);
        logic [BYTE_W-1:0] book [CODEBOOK_SIZE];
        logic [BYTE_W-1:0] flag_byte;
        logic [BYTE_W-1:0] index_byte;
        logic [BYTE_W-1:0] fixed_flags [4];
        fixed_flags = '{8'h00, 8'hFF, 8'hAA, 8'h55};
        send_byte(header);
        foreach (book[a]) book[a] = 8'($urandom);
        if (directed) begin
            // Column-wise layout: sample j of chunk k lives at k + 256 * j.
            book[0]                                       = 8'h00;
            book[CHUNKS_PER_FRAME]                        = 8'hFF;
            book[2 * CHUNKS_PER_FRAME]                    = 8'h01;
            book[3 * CHUNKS_PER_FRAME]                    = 8'hFE;
            book[CHUNKS_PER_FRAME - 1]                    = 8'hFF;
            book[2 * CHUNKS_PER_FRAME - 1]                = 8'h00;
            book[3 * CHUNKS_PER_FRAME - 1]                = 8'h80;
            book[4 * CHUNKS_PER_FRAME - 1]                = 8'h7F;
        end
        foreach (book[a]) send_byte(book[a]);
        for (int blk = 0; blk < blocks; blk++) begin
            flag_byte = 8'($urandom);
            if (directed && blk < 4) begin
                flag_byte = fixed_flags[blk];
            end
            send_byte(flag_byte);
            for (int c = 0; c < BLOCK_CHUNKS; c++) begin
                index_byte = 8'($urandom);
                if (directed && blk < 4) begin
                    index_byte = c[0] ? 8'hFF : 8'h00;
                end
                send_byte(index_byte);
            end
        end
    endtask

    // Receiver: each phase picks an eight-bit ready pattern and walks through
    // it cycle by cycle; an all-ones pattern gives a stretch without stalls.
    // Twice in the run the receiver holds off completely for a long stretch
    // while index requests keep arriving, so the decoder has to stall its input.
    initial begin : receiver
        int unsigned       phase_len;
        int unsigned       hold_offs;
        int unsigned       tick;
        logic [7:0]        pattern;
        hold_offs = 0;
        tick      = 0;
        forever begin
            pattern   = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
            phase_len = $urandom_range(32, 256);
            repeat (phase_len) begin
                @(negedge i_clk);
                if (hold_offs < 2 &&
                    tracker.samples_checked >= ((hold_offs == 0) ? 200 : 450)) begin
                    i_ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                    hold_offs++;
                end
                i_ready <= pattern[tick % 8];
                tick++;
            end
        end
    end

    // Results are taken at the rising edge at which valid and ready are both high.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            tracker.check_sample({o_dac_high, o_dac_low_bit, o_last_of_chunk,
                                  o_end_of_track});
        end
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // End of track straight out of reset, and a second one back to back.
        send_byte(8'h00);
        send_byte(8'h00);

        // One frame with a random non-zero header and directed extremes at its
        // start. The stream stops after FRAME_BLOCKS blocks, since even the shortest
        // frame runs to thousands of requests.
        play_frame(8'($urandom_range(1, 255)), FRAME_BLOCKS, 1'b1);

        i_valid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        tracker.flush_leftovers();

        $display("Streamed %0d bytes across %0d frames and %0d end-of-track headers.",
                 bytes_sent, tracker.frames_started, tracker.track_ends);
        $display("Checked %0d DAC samples; %0d mismatches in total.",
                 tracker.samples_checked, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("chunk_codebook_audio_decoder: match");
        end else begin
            $display("chunk_codebook_audio_decoder: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("Timed out with %0d samples still awaited.", tracker.awaited.size());
        $display("chunk_codebook_audio_decoder: mismatch");
        $finish;
    end

endmodule
